// ===== sv/hnp_pkg.sv =====
// shared types, register codes and constants of the half-pixel to nv12 packer
`timescale 1ns / 1ps
`default_nettype none

package hnp_pkg;

  localparam int DefMaxDimension = 4096;
  localparam int DefOffsetWidth  = 25;

  localparam int CfgIdxWidth  = 3;
  localparam int CfgDataWidth = 14;
  localparam int DimWidth     = 13;
  localparam int ChanCfgWidth = 5;
  localparam int StrideWidth  = 14;
  localparam int ChanWidth    = 4;
  localparam int HalfWidth    = 16;
  localparam int ByteWidth    = 8;

  localparam logic [DimWidth-1:0]     ResetFrameWidth  = 13'd1920;
  localparam logic [DimWidth-1:0]     ResetFrameHeight = 13'd1080;
  localparam logic [ChanCfgWidth-1:0] ResetChannels    = 5'd3;
  localparam logic [StrideWidth-1:0]  ResetLumaStride  = 14'd1920;
  localparam logic [StrideWidth-1:0]  ResetChromaStride = 14'd1920;

  // channel codes within a pixel
  localparam logic [ChanWidth-1:0] ChanY = 4'd0;
  localparam logic [ChanWidth-1:0] ChanU = 4'd1;
  localparam logic [ChanWidth-1:0] ChanV = 4'd2;

  // clamp limits of the channel count and of the last channel index
  localparam logic [ChanCfgWidth-1:0] ChanCfgMin  = 5'd3;
  localparam logic [ChanCfgWidth-1:0] ChanCfgMax  = 5'd16;
  localparam logic [ChanWidth-1:0]    LastChanMin = 4'd2;
  localparam logic [ChanWidth-1:0]    LastChanMax = 4'd15;

  localparam logic PlaneLuma   = 1'b0;
  localparam logic PlaneChroma = 1'b1;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_CHANNELS      = 3'd2,
    REG_LUMA_STRIDE   = 3'd3,
    REG_CHROMA_STRIDE = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [DimWidth-1:0]     frame_width;
    logic [DimWidth-1:0]     frame_height;
    logic [ChanCfgWidth-1:0] channels_per_pixel;
    logic [StrideWidth-1:0]  luma_stride;
    logic [StrideWidth-1:0]  chroma_stride;
  } cfg_t;

  // item held between address stage and conversion stage
  typedef struct packed {
    logic [HalfWidth-1:0] word;
    logic                 plane;
    logic                 done;
  } stage_t;

endpackage

`default_nettype wire

// ===== sv/hnp_cfg_regs.sv =====
// configuration register bank of the packer
`timescale 1ns / 1ps
`default_nettype none

module hnp_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [hnp_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [hnp_pkg::CfgDataWidth-1:0] cfg_data_i,
  output hnp_pkg::cfg_t                   cfg_o
);
  import hnp_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;

  assign idx         = reg_idx_e'(cfg_index_i);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (idx)
        REG_FRAME_WIDTH:   cfg_d.frame_width        = cfg_data_i[DimWidth-1:0];
        REG_FRAME_HEIGHT:  cfg_d.frame_height       = cfg_data_i[DimWidth-1:0];
        REG_CHANNELS:      cfg_d.channels_per_pixel = cfg_data_i[ChanCfgWidth-1:0];
        REG_LUMA_STRIDE:   cfg_d.luma_stride        = cfg_data_i[StrideWidth-1:0];
        REG_CHROMA_STRIDE: cfg_d.chroma_stride      = cfg_data_i[StrideWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width        <= ResetFrameWidth;
      cfg_q.frame_height       <= ResetFrameHeight;
      cfg_q.channels_per_pixel <= ResetChannels;
      cfg_q.luma_stride        <= ResetLumaStride;
      cfg_q.chroma_stride      <= ResetChromaStride;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== sv/hnp_addr_gen.sv =====
// frame position counters, plane offsets and the input register stage
`timescale 1ns / 1ps
`default_nettype none

module hnp_addr_gen #(
  parameter int MAX_DIMENSION = hnp_pkg::DefMaxDimension,
  parameter int OFFSET_WIDTH  = hnp_pkg::DefOffsetWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hnp_pkg::cfg_t                 cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [hnp_pkg::HalfWidth-1:0] half_sample_i,
  input  logic                          s1_ready_i,
  output logic                          s1_valid_o,
  output hnp_pkg::stage_t               s1_o,
  output logic [OFFSET_WIDTH-1:0]       s1_offset_o
);
  import hnp_pkg::*;

  localparam int DW = $clog2(MAX_DIMENSION);
  localparam logic [DimWidth:0] MaxDimCmp = (DimWidth + 1)'(MAX_DIMENSION);

  logic [ChanWidth-1:0]    ch_q, ch_d;
  logic [DW-1:0]           col_q, col_d;
  logic [DW-1:0]           row_q, row_d;
  logic [OFFSET_WIDTH-1:0] lbase_q, lbase_d;
  logic [OFFSET_WIDTH-1:0] cbase_q, cbase_d;

  logic                    s1_valid_q;
  stage_t                  s1_q;
  logic [OFFSET_WIDTH-1:0] off_q;

  logic [DW-1:0]           wm1, hm1;
  logic [DW:0]             w_full, h_full;
  logic [ChanWidth-1:0]    cpm1;
  logic                    last_ch, last_col, last_row, done;
  logic                    chroma_ok, has_result, in_accept;
  logic [OFFSET_WIDTH-1:0] luma_off, chroma_off, item_off;

  // clamp frame size to 1..MAX_DIMENSION, kept as size minus one
  always_comb begin
    if (cfg_i.frame_width == '0) begin
      wm1 = '0;
    end else if ({1'b0, cfg_i.frame_width} > MaxDimCmp) begin
      wm1 = DW'(MAX_DIMENSION - 1);
    end else begin
      wm1 = DW'(cfg_i.frame_width - 13'd1);
    end
    if (cfg_i.frame_height == '0) begin
      hm1 = '0;
    end else if ({1'b0, cfg_i.frame_height} > MaxDimCmp) begin
      hm1 = DW'(MAX_DIMENSION - 1);
    end else begin
      hm1 = DW'(cfg_i.frame_height - 13'd1);
    end
    if (cfg_i.channels_per_pixel < ChanCfgMin) begin
      cpm1 = LastChanMin;
    end else if (cfg_i.channels_per_pixel > ChanCfgMax) begin
      cpm1 = LastChanMax;
    end else begin
      cpm1 = ChanWidth'(cfg_i.channels_per_pixel - 5'd1);
    end
  end

  assign w_full = {1'b0, wm1} + (DW + 1)'(1);
  assign h_full = {1'b0, hm1} + (DW + 1)'(1);

  assign last_ch  = ch_q >= cpm1;
  assign last_col = col_q >= wm1;
  assign last_row = row_q >= hm1;
  assign done     = last_ch && last_col && last_row;

  // chroma only from the top-left pixel of a complete 2x2 block
  assign chroma_ok = !row_q[0] && !col_q[0] &&
                     (({1'b0, row_q} >> 1) < (h_full >> 1)) &&
                     (({1'b0, col_q} >> 1) < (w_full >> 1));

  assign has_result = (ch_q == ChanY) ||
                      (((ch_q == ChanU) || (ch_q == ChanV)) && chroma_ok);

  assign luma_off   = lbase_q + OFFSET_WIDTH'(col_q);
  assign chroma_off = cbase_q + OFFSET_WIDTH'(col_q) + OFFSET_WIDTH'(ch_q == ChanV);
  assign item_off   = (ch_q == ChanY) ? luma_off : chroma_off;

  assign in_stall_o = s1_valid_q && !s1_ready_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    ch_d    = ch_q;
    col_d   = col_q;
    row_d   = row_q;
    lbase_d = lbase_q;
    cbase_d = cbase_q;
    if (in_accept) begin
      if (!last_ch) begin
        ch_d = ch_q + ChanWidth'(1);
      end else begin
        ch_d = '0;
        if (!last_col) begin
          col_d = col_q + DW'(1);
        end else begin
          col_d = '0;
          if (!last_row) begin
            if (row_q[0]) begin
              cbase_d = cbase_q + OFFSET_WIDTH'(cfg_i.chroma_stride);
            end
            row_d   = row_q + DW'(1);
            lbase_d = lbase_q + OFFSET_WIDTH'(cfg_i.luma_stride);
          end else begin
            row_d   = '0;
            lbase_d = '0;
            cbase_d = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q       <= '0;
      col_q      <= '0;
      row_q      <= '0;
      lbase_q    <= '0;
      cbase_q    <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      ch_q    <= ch_d;
      col_q   <= col_d;
      row_q   <= row_d;
      lbase_q <= lbase_d;
      cbase_q <= cbase_d;
      if (!in_stall_o) begin
        s1_valid_q <= in_accept && has_result;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && has_result) begin
      s1_q.word  <= half_sample_i;
      s1_q.plane <= (ch_q == ChanY) ? PlaneLuma : PlaneChroma;
      s1_q.done  <= done;
      off_q      <= item_off;
    end
  end

  assign s1_valid_o  = s1_valid_q;
  assign s1_o        = s1_q;
  assign s1_offset_o = off_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_ready_i |=> s1_valid_q && $stable(off_q))
    else $error("held item changed while stalled");

  a_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && done |=> ch_q == '0 && col_q == '0 && row_q == '0 &&
                          lbase_q == '0 && cbase_q == '0)
    else $error("counters not cleared after final word");

  a_chroma_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && has_result && ch_q != ChanY |-> !row_q[0] && !col_q[0])
    else $error("chroma item at odd position");

endmodule

`default_nettype wire

// ===== sv/hnp_convert.sv =====
// fp16 times 255 with round half to even and saturation, plus result register
`timescale 1ns / 1ps
`default_nettype none

module hnp_convert #(
  parameter int OFFSET_WIDTH = hnp_pkg::DefOffsetWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s1_valid_i,
  output logic                          s1_ready_o,
  input  hnp_pkg::stage_t               s1_i,
  input  logic [OFFSET_WIDTH-1:0]       s1_offset_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [hnp_pkg::ByteWidth-1:0] byte_value_o,
  output logic                          plane_select_o,
  output logic [OFFSET_WIDTH-1:0]       byte_offset_o,
  output logic                          frame_done_o
);
  import hnp_pkg::*;

  function automatic logic [ByteWidth-1:0] half_to_byte(input logic [HalfWidth-1:0] h);
    logic                 sgn;
    logic [4:0]           ex;
    logic [9:0]           man;
    logic [10:0]          sig;
    logic [18:0]          p;
    logic [4:0]           k;
    logic [24:0]          pw;
    logic [19:0]          q;
    logic [24:0]          rem;
    logic [24:0]          hlf;
    logic [ByteWidth-1:0] res;
    sgn = h[15];
    ex  = h[14:10];
    man = h[9:0];
    res = '0;
    if (ex == 5'd31) begin
      res = (man != '0 || sgn) ? 8'd0 : 8'd255;
    end else if (!sgn) begin
      sig = (ex == 5'd0) ? {1'b0, man} : {1'b1, man};
      // sig * 255 as a shift and subtract
      p = {sig, 8'b0} - {8'b0, sig};
      if (p == '0) begin
        res = 8'd0;
      end else if (ex >= 5'd25) begin
        res = 8'd255;
      end else begin
        k   = (ex == 5'd0) ? 5'd24 : 5'd25 - ex;
        pw  = {6'b0, p};
        q   = 20'(pw >> k);
        rem = pw & ((25'd1 << k) - 25'd1);
        hlf = 25'd1 << (k - 5'd1);
        if (rem > hlf || (rem == hlf && q[0])) begin
          q = q + 20'd1;
        end
        res = (q > 20'd255) ? 8'd255 : q[7:0];
      end
    end
    return res;
  endfunction

  logic                    out_valid_q;
  logic [ByteWidth-1:0]    byte_q;
  logic                    plane_q;
  logic [OFFSET_WIDTH-1:0] off_q;
  logic                    done_q;
  logic                    load_en;

  assign load_en    = !out_valid_q || !out_stall_i;
  assign s1_ready_o = load_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_en) begin
      out_valid_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en && s1_valid_i) begin
      byte_q  <= half_to_byte(s1_i.word);
      plane_q <= s1_i.plane;
      off_q   <= s1_offset_i;
      done_q  <= s1_i.done;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign byte_value_o   = byte_q;
  assign plane_select_o = plane_q;
  assign byte_offset_o  = off_q;
  assign frame_done_o   = done_q;

  a_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_i && s1_ready_o |=> out_valid_q)
    else $error("item lost between stages");

  a_pos_inf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_i && s1_ready_o && s1_i.word == 16'h7C00 |=> byte_q == 8'd255)
    else $error("positive infinity not saturated");

  a_negative: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_i && s1_ready_o && s1_i.word[15] |=> byte_q == 8'd0)
    else $error("negative word gave nonzero byte");

endmodule

`default_nettype wire

// ===== sv/half_pixel_to_nv12_packer_top.sv =====
// Half-precision pixel to NV12 packer, top level.
//
// Input channel: one fp16 channel word per item on half_sample_i, pixel-major,
// channels_per_pixel words per pixel, rows in order; channel 0 is Y, 1 is U,
// 2 is V, higher channels are consumed without a result. Each Y word yields a
// luma byte; U and V yield interleaved chroma bytes at even rows and columns
// of the complete 2x2 area. frame_done_o marks the result of the frame's last
// word, if that word yields one. Configuration writes go through cfg_valid_i/
// cfg_index_i/cfg_data_i, always ready, and take effect on the next item.
// Throughput: one item per clock while the input is not stalled. A result
// passes the frame counters and offset adder into the input register, then
// the fp16 multiply-round unit into the result register.
// A receiver stall holds the result register; the input register keeps one
// more item, and the input stalls only when both are full.
// Reset clears the frame position and both row bases and loads the default
// 1920x1080, three channel, 1920 byte stride configuration.
`timescale 1ns / 1ps
`default_nettype none

module half_pixel_to_nv12_packer_top #(
  parameter int MAX_DIMENSION = hnp_pkg::DefMaxDimension,
  parameter int OFFSET_WIDTH  = hnp_pkg::DefOffsetWidth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [hnp_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [hnp_pkg::CfgDataWidth-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [hnp_pkg::HalfWidth-1:0]   half_sample_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [hnp_pkg::ByteWidth-1:0]   byte_value_o,
  output logic                            plane_select_o,
  output logic [OFFSET_WIDTH-1:0]         byte_offset_o,
  output logic                            frame_done_o
);
  import hnp_pkg::*;

  cfg_t                    cfg;
  logic                    s1_valid;
  logic                    s1_ready;
  stage_t                  s1;
  logic [OFFSET_WIDTH-1:0] s1_offset;

  hnp_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  hnp_addr_gen #(
    .MAX_DIMENSION (MAX_DIMENSION),
    .OFFSET_WIDTH  (OFFSET_WIDTH)
  ) u_addr_gen (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .half_sample_i (half_sample_i),
    .s1_ready_i    (s1_ready),
    .s1_valid_o    (s1_valid),
    .s1_o          (s1),
    .s1_offset_o   (s1_offset)
  );

  hnp_convert #(
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_convert (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s1_valid_i     (s1_valid),
    .s1_ready_o     (s1_ready),
    .s1_i           (s1),
    .s1_offset_i    (s1_offset),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .byte_value_o   (byte_value_o),
    .plane_select_o (plane_select_o),
    .byte_offset_o  (byte_offset_o),
    .frame_done_o   (frame_done_o)
  );

endmodule

`default_nettype wire

// ===== tb/tb_half_pixel_to_nv12_packer_top.sv =====
// self-checking testbench of the half-pixel to nv12 packer
`timescale 1ns / 1ps

module tb_half_pixel_to_nv12_packer_top;
  import hnp_pkg::*;

  localparam int OffW = DefOffsetWidth;
  localparam int MaxDim = DefMaxDimension;
  localparam int SettleCycles = 8;
  localparam int RandomItems = 1200;
  localparam logic [CfgIdxWidth-1:0] RegIdxFirstSpare = 3'd5;
  localparam logic [CfgIdxWidth-1:0] RegIdxLastSpare = 3'd7;

  typedef struct packed {
    logic [ByteWidth-1:0] byte_value;
    logic                 plane;
    logic [OffW-1:0]      offset;
    logic                 done;
  } nv12_byte_t;

  // byte value typed in for a table row where it is obvious
  typedef struct packed {
    logic                 pinned;
    logic [ByteWidth-1:0] value;
  } pin_t;

  typedef struct packed {
    logic [HalfWidth-1:0] word;
    logic                 pinned;
    logic [ByteWidth-1:0] value;
  } conv_row_t;

  // reset configuration: 3 channels, 1920 wide, walked pixel by pixel from column 0
  localparam conv_row_t ConvTable [24] = '{
    '{16'h3C00, 1'b1, 8'd255}, '{16'h0000, 1'b1, 8'd0},   '{16'h7C00, 1'b1, 8'd255},
    '{16'h8000, 1'b1, 8'd0},   '{16'h3C00, 1'b0, 8'd0},   '{16'h3C00, 1'b0, 8'd0},
    '{16'h3800, 1'b1, 8'd128}, '{16'hFC00, 1'b1, 8'd0},   '{16'h7E00, 1'b1, 8'd0},
    '{16'hFE00, 1'b1, 8'd0},   '{16'h6400, 1'b0, 8'd0},   '{16'hFFFF, 1'b0, 8'd0},
    '{16'h7BFF, 1'b1, 8'd255}, '{16'h0001, 1'b0, 8'd0},   '{16'h03FF, 1'b0, 8'd0},
    '{16'hBC00, 1'b1, 8'd0},   '{16'h5BF8, 1'b0, 8'd0},   '{16'h0400, 1'b0, 8'd0},
    '{16'h2000, 1'b0, 8'd0},   '{16'h1C00, 1'b0, 8'd0},   '{16'h5BF8, 1'b1, 8'd255},
    '{16'hFFFF, 1'b1, 8'd0},   '{16'h3A00, 1'b0, 8'd0},   '{16'h3600, 1'b0, 8'd0}
  };

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CfgIdxWidth-1:0]  cfg_index_i = '0;
  logic [CfgDataWidth-1:0] cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [HalfWidth-1:0]    half_sample_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [ByteWidth-1:0]    byte_value_o;
  logic                    plane_select_o;
  logic [OffW-1:0]         byte_offset_o;
  logic                    frame_done_o;

  // predictor copy of the registers and frame position
  cfg_t                pack_cfg = '{ResetFrameWidth, ResetFrameHeight, ResetChannels,
                                    ResetLumaStride, ResetChromaStride};
  logic [ChanWidth-1:0] chan_idx = '0;
  int unsigned          col_idx = 0;
  int unsigned          row_idx = 0;
  logic [OffW-1:0]      luma_base = '0;
  logic [OffW-1:0]      chroma_base = '0;

  nv12_byte_t nv12_pending_q[$];
  pin_t       pinned_byte_q[$];
  int         mismatches = 0;
  bit         tx_idle_en = 1'b1;
  bit         rx_idle_en = 1'b1;
  int         hold_cycles = 0;

  half_pixel_to_nv12_packer_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .half_sample_i (half_sample_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .byte_value_o  (byte_value_o),
    .plane_select_o(plane_select_o),
    .byte_offset_o (byte_offset_o),
    .frame_done_o  (frame_done_o)
  );

  always #5 clk_i = ~clk_i;

  // fp16 times 255, round half to even, saturate to a byte
  function automatic logic [ByteWidth-1:0] half_to_unorm8(input logic [HalfWidth-1:0] h);
    logic [4:0]  ex;
    logic [9:0]  man;
    int unsigned sig, prod, sh, q, rem, halfway;
    ex = h[14:10];
    man = h[9:0];
    if (ex == 5'd31) return (man != 0 || h[15]) ? 8'd0 : 8'd255;
    if (h[15]) return 8'd0;
    sig = (ex == 0) ? man : (32'(man) | 32'd1024);
    prod = sig * 255;
    if (prod == 0) return 8'd0;
    if (ex >= 5'd25) return 8'd255;
    sh = (ex == 0) ? 24 : 25 - ex;
    q = prod >> sh;
    rem = prod & ((32'd1 << sh) - 1);
    halfway = 32'd1 << (sh - 1);
    if (rem > halfway || (rem == halfway && q[0])) q++;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  // one channel word into the frame; returns 1 when it yields a plane byte
  function automatic bit pack_half_word(input logic [HalfWidth-1:0] word,
                                        output nv12_byte_t res);
    int unsigned w_eff, h_eff, c_eff;
    bit last_ch, last_col, last_row, chroma_ok, hit;
    w_eff = (pack_cfg.frame_width == 0) ? 1 :
            (pack_cfg.frame_width > MaxDim) ? MaxDim : pack_cfg.frame_width;
    h_eff = (pack_cfg.frame_height == 0) ? 1 :
            (pack_cfg.frame_height > MaxDim) ? MaxDim : pack_cfg.frame_height;
    c_eff = (pack_cfg.channels_per_pixel < ChanCfgMin) ? ChanCfgMin :
            (pack_cfg.channels_per_pixel > ChanCfgMax) ? ChanCfgMax :
            pack_cfg.channels_per_pixel;
    last_ch = chan_idx >= c_eff - 1;
    last_col = col_idx >= w_eff - 1;
    last_row = row_idx >= h_eff - 1;
    chroma_ok = !row_idx[0] && !col_idx[0] && (row_idx >> 1) < (h_eff >> 1) &&
                (col_idx >> 1) < (w_eff >> 1);
    hit = 1'b0;
    res = '0;
    if (chan_idx == ChanY) begin
      res = '{half_to_unorm8(word), PlaneLuma, luma_base + OffW'(col_idx),
              last_ch && last_col && last_row};
      hit = 1'b1;
    end else if ((chan_idx == ChanU || chan_idx == ChanV) && chroma_ok) begin
      res = '{half_to_unorm8(word), PlaneChroma,
              chroma_base + OffW'(col_idx) + OffW'(chan_idx == ChanV),
              last_ch && last_col && last_row};
      hit = 1'b1;
    end
    if (!last_ch) begin
      chan_idx = chan_idx + 1'b1;
    end else begin
      chan_idx = ChanY;
      if (!last_col) begin
        col_idx++;
      end else begin
        col_idx = 0;
        if (!last_row) begin
          if (row_idx[0]) chroma_base = chroma_base + OffW'(pack_cfg.chroma_stride);
          row_idx++;
          luma_base = luma_base + OffW'(pack_cfg.luma_stride);
        end else begin
          row_idx = 0;
          luma_base = '0;
          chroma_base = '0;
        end
      end
    end
    return hit;
  endfunction

  function automatic void apply_reg_write(input logic [CfgIdxWidth-1:0] idx,
                                          input logic [CfgDataWidth-1:0] data);
    case (idx)
      REG_FRAME_WIDTH:   pack_cfg.frame_width = data[DimWidth-1:0];
      REG_FRAME_HEIGHT:  pack_cfg.frame_height = data[DimWidth-1:0];
      REG_CHANNELS:      pack_cfg.channels_per_pixel = data[ChanCfgWidth-1:0];
      REG_LUMA_STRIDE:   pack_cfg.luma_stride = data[StrideWidth-1:0];
      REG_CHROMA_STRIDE: pack_cfg.chroma_stride = data[StrideWidth-1:0];
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  // register writes, accepted items and results, all sampled at the same edge
  always @(posedge clk_i) begin : scoreboard
    nv12_byte_t pred_b, want_b;
    pin_t       pin;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) apply_reg_write(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_o) begin
        pin = pinned_byte_q.pop_front();
        if (pack_half_word(half_sample_i, pred_b)) begin
          if (pin.pinned) pred_b.byte_value = pin.value;
          nv12_pending_q.push_back(pred_b);
        end
      end
      if (out_valid_o && !out_stall_i) begin
        if (nv12_pending_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual byte %0d offset %0d",
                   $time, byte_value_o, byte_offset_o);
        end else begin
          want_b = nv12_pending_q.pop_front();
          check_field("byte_value", 32'(want_b.byte_value), 32'(byte_value_o));
          check_field("plane_select", 32'(want_b.plane), 32'(plane_select_o));
          check_field("byte_offset", 32'(want_b.offset), 32'(byte_offset_o));
          check_field("frame_done", 32'(want_b.done), 32'(frame_done_o));
        end
      end
    end
  end

  // receiver stalls: random bursts, plus a long hold-off on request
  initial begin : rx_side
    int burst;
    burst = 0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall_i <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall_i <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(0, 5);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_half(input logic [HalfWidth-1:0] word, input logic pinned,
                           input logic [ByteWidth-1:0] value);
    pinned_byte_q.push_back('{pinned, value});
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    half_sample_i <= word;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic cfg_write(input logic [CfgIdxWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // wait for every expected byte, then for items still in flight without one
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (nv12_pending_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [HalfWidth-1:0] random_half();
    case ($urandom_range(0, 3))
      0, 1: return HalfWidth'($urandom_range(0, 16'h3C00));
      2: return HalfWidth'($urandom);
      default: begin
        if ($urandom_range(0, 1) == 1)
          return {1'($urandom), 5'($urandom_range(22, 31)), 10'($urandom)};
        return {1'($urandom), 5'($urandom_range(0, 2)), 10'($urandom)};
      end
    endcase
  endfunction

  task automatic run_phase(input logic [CfgDataWidth-1:0] width, height, chans,
                           input logic [CfgDataWidth-1:0] lstride, cstride,
                           input int n_items, input bit spare, input int hold);
    wait_drained();
    cfg_write(REG_FRAME_WIDTH, width);
    cfg_write(REG_FRAME_HEIGHT, height);
    cfg_write(REG_CHANNELS, chans);
    cfg_write(REG_LUMA_STRIDE, lstride);
    cfg_write(REG_CHROMA_STRIDE, cstride);
    if (spare)
      cfg_write(CfgIdxWidth'($urandom_range(RegIdxFirstSpare, RegIdxLastSpare)),
                CfgDataWidth'($urandom));
    cfg_valid_i <= 1'b0;
    hold_cycles = hold;
    repeat (n_items) send_half(random_half(), 1'b0, '0);
  endtask

  initial begin : stimulus
    int unsigned w, h, c, c_eff, n;
    int          rand_items, phase_no;
    logic [CfgDataWidth-1:0] w_cfg, c_cfg, ls, cs;
    rand_items = 0;
    phase_no = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (ConvTable[i]) send_half(ConvTable[i].word, ConvTable[i].pinned, ConvTable[i].value);

    // odd last row and column, entered mid-frame
    run_phase(14'd3, 14'd3, 14'd3, 14'd5, 14'd7, 54, 1'b1, 0);
    // unused channels, final word gives no result
    run_phase(14'd4, 14'd2, 14'd5, 14'd4, 14'd6, 80, 1'b0, 0);
    // sizes below the clamp, zero strides
    run_phase(14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 9, 1'b0, 0);
    // sizes above the clamp
    run_phase(14'h3FFF, 14'h1FFF, 14'd31, 14'h3FFF, 14'h3FFF, 48, 1'b0, 0);
    // tall single-column frame with the widest strides, back to back
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_phase(14'd1, 14'd4096, 14'd3, 14'h3FFF, 14'h3FFF, 3 * 60, 1'b0, 0);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;

    while (rand_items < RandomItems) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      h = $urandom_range(1, 8);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: c = 3;
        6, 7: c = $urandom_range(4, 6);
        8: c = $urandom_range(7, 16);
        default: c = $urandom_range(0, 31);
      endcase
      c_eff = (c < ChanCfgMin) ? ChanCfgMin : (c > ChanCfgMax) ? ChanCfgMax : c;
      w_cfg = CfgDataWidth'(w);
      if ($urandom_range(0, 7) == 0) w_cfg[CfgDataWidth-1] = 1'b1;
      c_cfg = CfgDataWidth'(c);
      if ($urandom_range(0, 7) == 0) c_cfg = c_cfg | (CfgDataWidth'($urandom) & 14'h3FE0);
      ls = ($urandom_range(0, 3) == 0) ? CfgDataWidth'($urandom) :
           CfgDataWidth'($urandom_range(w, w + 3));
      cs = ($urandom_range(0, 3) == 0) ? CfgDataWidth'($urandom) :
           CfgDataWidth'($urandom_range(w, w + 3));
      n = w * h * c_eff * $urandom_range(1, 3);
      if ($urandom_range(0, 4) == 0) n += $urandom_range(1, w * h * c_eff);
      if (n > 300) n = 300;
      if (rand_items > RandomItems - 300) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      if (phase_no == 2) begin
        // long receiver hold-off while the sender keeps going
        if (n < 40) n = 40;
        tx_idle_en = 1'b0;
        run_phase(w_cfg, CfgDataWidth'(h), c_cfg, ls, cs, n, 1'b0, 64);
        tx_idle_en = 1'b1;
      end else begin
        run_phase(w_cfg, CfgDataWidth'(h), c_cfg, ls, cs, n, $urandom_range(0, 2) == 0, 0);
      end
      rand_items += n;
      phase_no++;
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
